### rtl/btm_pkg.sv
`timescale 1ns / 1ps
// Package for the battery trend monitor: widths, register indexes, reset values,
// the configuration struct and the sample scaling function. No dependencies.
package btm_pkg;

  localparam int PIN_W     = 12;
  localparam int RATIO_W   = 10;
  localparam int MV_W      = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 14;
  localparam int FRAC_W    = 8;
  localparam int PROD_W    = PIN_W + RATIO_W;

  localparam logic [MV_W-1:0] MV_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_RATIO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_MV       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_MV       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MV       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MV        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_USE_PIN       = 3'd5;

  localparam logic [RATIO_W-1:0] RST_DIVIDER_RATIO = 10'd512;
  localparam logic [MV_W-1:0]    RST_RISE_MV       = 14'd50;
  localparam logic [MV_W-1:0]    RST_FALL_MV       = 14'd50;
  localparam logic [MV_W-1:0]    RST_FULL_MV       = 14'd4150;
  localparam logic [MV_W-1:0]    RST_LOW_MV        = 14'd3400;

  typedef struct packed {
    logic [RATIO_W-1:0] divider_ratio_q8;
    logic [MV_W-1:0]    rise_mv;
    logic [MV_W-1:0]    fall_mv;
    logic [MV_W-1:0]    full_mv;
    logic [MV_W-1:0]    low_mv;
    logic               use_charge_pin;
  } cfg_t;

  function automatic logic [MV_W-1:0] scale_mv(input logic [PIN_W-1:0] pin,
                                               input logic [RATIO_W-1:0] ratio);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-FRAC_W-1:0] shifted;
    prod = PROD_W'(pin) * PROD_W'(ratio);
    shifted = prod[PROD_W-1:FRAC_W];
    if (shifted > (PROD_W-FRAC_W)'(MV_MAX)) begin
      scale_mv = MV_MAX;
    end else begin
      scale_mv = MV_W'(shifted);
    end
  endfunction

endpackage

### rtl/btm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample requests and the results.
// Depends on btm_pkg for field widths.
interface btm_in_if;
  logic                        valid;
  logic                        ready;
  logic [btm_pkg::PIN_W-1:0]   pin_mv;
  logic                        read_ok;
  logic                        charge_pin_level;

  modport source (output valid, output pin_mv, output read_ok, output charge_pin_level,
                  input ready);
  modport sink (input valid, input pin_mv, input read_ok, input charge_pin_level,
                output ready);
endinterface

interface btm_out_if;
  logic                       valid;
  logic                       ready;
  logic [btm_pkg::MV_W-1:0]   battery_mv;
  logic                       charging;
  logic                       is_full;
  logic                       is_low;

  modport source (output valid, output battery_mv, output charging, output is_full,
                  output is_low, input ready);
  modport sink (input valid, input battery_mv, input charging, input is_full,
                input is_low, output ready);
endinterface

### rtl/btm_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the battery trend monitor.
// Depends on btm_pkg for register indexes, reset values and cfg_t.
module btm_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [btm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [btm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output btm_pkg::cfg_t                     cfg
);

  btm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.divider_ratio_q8 <= btm_pkg::RST_DIVIDER_RATIO;
      cfg_r.rise_mv          <= btm_pkg::RST_RISE_MV;
      cfg_r.fall_mv          <= btm_pkg::RST_FALL_MV;
      cfg_r.full_mv          <= btm_pkg::RST_FULL_MV;
      cfg_r.low_mv           <= btm_pkg::RST_LOW_MV;
      cfg_r.use_charge_pin   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        btm_pkg::REG_DIVIDER_RATIO: begin
          cfg_r.divider_ratio_q8 <= cfg_wdata[btm_pkg::RATIO_W-1:0];
        end
        btm_pkg::REG_RISE_MV: begin
          cfg_r.rise_mv <= cfg_wdata[btm_pkg::MV_W-1:0];
        end
        btm_pkg::REG_FALL_MV: begin
          cfg_r.fall_mv <= cfg_wdata[btm_pkg::MV_W-1:0];
        end
        btm_pkg::REG_FULL_MV: begin
          cfg_r.full_mv <= cfg_wdata[btm_pkg::MV_W-1:0];
        end
        btm_pkg::REG_LOW_MV: begin
          cfg_r.low_mv <= cfg_wdata[btm_pkg::MV_W-1:0];
        end
        btm_pkg::REG_USE_PIN: begin
          cfg_r.use_charge_pin <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/btm_ring_mem.sv
`timescale 1ns / 1ps
// Sample ring storage: one write port and one read port with registered read data.
// No dependencies.
module btm_ring_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/battery_trend_monitor_top.sv
`timescale 1ns / 1ps
// Battery trend monitor top level: request pipeline, ring memory and verdict logic.
// Depends on btm_pkg, btm_if, btm_cfg_regs and btm_ring_mem.

// The block takes one sample request per clock cycle unless the output stalls. The sample
// ring lives in one memory of WINDOW entries; at acceptance the oldest sample is read, as
// the request moves into the second stage the new sample is scaled and written, and as it
// moves into the output register the trend verdict is formed there. Each request costs one
// memory read and one memory write, so the rate is one request per cycle while nothing
// stalls. The ring needs no clearing pass after reset, since the oldest sample is only
// used once the window has been filled.
module battery_trend_monitor_top #(
  parameter int WINDOW = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  btm_in_if.sink                          in_req,
  btm_out_if.source                       out_res,
  input  logic                            cfg_we,
  input  logic [btm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [btm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int MW = btm_pkg::MV_W;

  btm_pkg::cfg_t cfg;

  logic [AW-1:0]             ws_r;
  logic [AW-1:0]             rd_addr;
  logic [CW-1:0]             fill_r;
  logic [MW-1:0]             last_r;
  logic                      chg_r;

  logic                      s1_valid_r;
  logic [btm_pkg::PIN_W-1:0] s1_pin_r;
  logic                      s1_ok_r;
  logic                      s1_level_r;
  logic [AW-1:0]             s1_slot_r;
  logic                      s1_fwd_r;
  logic [MW-1:0]             s1_fwd_data_r;
  logic [MW-1:0]             s1_v;
  logic [MW-1:0]             s1_old;
  logic [MW-1:0]             mem_rdata;

  logic                      s2_valid_r;
  logic [MW-1:0]             s2_v_r;
  logic [MW-1:0]             s2_old_r;
  logic                      s2_level_r;
  logic                      s2_full_r;

  logic                      out_valid_r;
  logic [MW-1:0]             out_mv_r;
  logic                      out_chg_r;
  logic                      out_full_r;
  logic                      out_low_r;

  logic                      in_acc;
  logic                      s2_adv;
  logic                      out_adv;
  logic                      chg_nxt;
  logic [MW:0]               rise;
  logic [MW:0]               fall;

  btm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign out_adv = s2_valid_r && (!out_valid_r || out_res.ready);
  assign s2_adv  = s1_valid_r && (!s2_valid_r || out_adv);
  assign in_req.ready = !s1_valid_r || s2_adv;
  assign in_acc  = in_req.valid && in_req.ready;

  assign rd_addr = (ws_r == AW'(WINDOW - 1)) ? '0 : ws_r + AW'(1);

  assign s1_v   = s1_ok_r ? btm_pkg::scale_mv(s1_pin_r, cfg.divider_ratio_q8) : last_r;
  assign s1_old = s1_fwd_r ? s1_fwd_data_r : mem_rdata;

  btm_ring_mem #(
    .DEPTH (WINDOW),
    .AW    (AW),
    .DW    (MW)
  ) u_ring (
    .clk   (clk),
    .we    (s2_adv),
    .waddr (s1_slot_r),
    .wdata (s1_v),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      ws_r       <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        ws_r       <= rd_addr;
      end else if (s2_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pin_r      <= in_req.pin_mv;
      s1_ok_r       <= in_req.read_ok;
      s1_level_r    <= in_req.charge_pin_level;
      s1_slot_r     <= ws_r;
      s1_fwd_r      <= s2_adv && (s1_slot_r == rd_addr);
      s1_fwd_data_r <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      last_r     <= '0;
      fill_r     <= '0;
    end else begin
      if (s2_adv) begin
        s2_valid_r <= 1'b1;
        last_r     <= s1_v;
        if (fill_r != CW'(WINDOW)) begin
          fill_r <= fill_r + CW'(1);
        end
      end else if (out_adv) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_v_r     <= s1_v;
      s2_old_r   <= s1_old;
      s2_level_r <= s1_level_r;
      s2_full_r  <= (fill_r >= CW'(WINDOW - 1));
    end
  end

  assign rise = {1'b0, s2_v_r} - {1'b0, s2_old_r};
  assign fall = {1'b0, s2_old_r} - {1'b0, s2_v_r};

  always_comb begin
    chg_nxt = chg_r;
    if (cfg.use_charge_pin) begin
      chg_nxt = !s2_level_r;
    end else if (s2_full_r) begin
      if (!rise[MW] && (rise[MW-1:0] >= cfg.rise_mv)) begin
        chg_nxt = 1'b1;
      end else if (!fall[MW] && (fall != '0) && (fall[MW-1:0] >= cfg.fall_mv)) begin
        chg_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      chg_r       <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_r <= 1'b1;
        chg_r       <= chg_nxt;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_mv_r   <= s2_v_r;
      out_chg_r  <= chg_nxt;
      out_full_r <= (s2_v_r >= cfg.full_mv);
      out_low_r  <= !chg_nxt && (s2_v_r != '0) && (s2_v_r < cfg.low_mv);
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.battery_mv = out_mv_r;
  assign out_res.charging   = out_chg_r;
  assign out_res.is_full    = out_full_r;
  assign out_res.is_low     = out_low_r;

endmodule
